/* sv/osp_pkg.sv */
// ----------------------------------------------------------------------------
// osp_pkg
// shared types, codes and defaults for the orthogonal segment pair finder
// ----------------------------------------------------------------------------
package osp_pkg;

  // default sizing
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  // fixed field widths of the transactions
  localparam int IN_COORD_W = 16;
  localparam int OUT_IDX_W  = 6;

  // op codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CROSS = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic                  op;
    logic                  vertical;
    logic [IN_COORD_W-1:0] xa;
    logic [IN_COORD_W-1:0] ya;
    logic [IN_COORD_W-1:0] xb;
    logic [IN_COORD_W-1:0] yb;
  } in_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [OUT_IDX_W-1:0] earlier_index;
    logic [OUT_IDX_W-1:0] new_index;
    logic [OUT_IDX_W-1:0] match_count;
    logic                 last;
  } out_t;

  // per-cell control broadcast along the ring
  typedef struct packed {
    logic rot;
    logic load;
  } cell_ctl_t;

endpackage

/* sv/osp_cell.sv */
// ----------------------------------------------------------------------------
// osp_cell
// one stored segment of the ring, rotates towards the head or loads a new entry
// ----------------------------------------------------------------------------
module osp_cell #(
  parameter int COORD_BITS = osp_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  osp_pkg::cell_ctl_t      ctl,
  input  logic [3*COORD_BITS:0]   load_data,
  input  logic [3*COORD_BITS:0]   from_next,
  output logic [3*COORD_BITS:0]   ent
);
  import osp_pkg::*;

  localparam int ENT_W = 3 * COORD_BITS + 1;

  logic [ENT_W-1:0] ent_r;
  logic [ENT_W-1:0] ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.load) begin
      ent_nxt = load_data;
    end else if (ctl.rot) begin
      ent_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

/* sv/osp_cmp.sv */
// ----------------------------------------------------------------------------
// osp_cmp
// strict crossing test between the probe and the segment at the ring head
// ----------------------------------------------------------------------------
module osp_cmp #(
  parameter int COORD_BITS = osp_pkg::COORD_BITS_DEF
) (
  input  logic [3*COORD_BITS:0] probe,
  input  logic [3*COORD_BITS:0] head,
  output logic                  hit
);
  import osp_pkg::*;

  // entry layout: {vertical, fixed, lo, hi}
  logic                  p_vert, h_vert;
  logic [COORD_BITS-1:0] v_fix, v_lo, v_hi;
  logic [COORD_BITS-1:0] h_fix, h_lo, h_hi;

  assign p_vert = probe[3*COORD_BITS];
  assign h_vert = head[3*COORD_BITS];

  always_comb begin
    if (p_vert) begin
      {v_fix, v_lo, v_hi} = probe[3*COORD_BITS-1:0];
      {h_fix, h_lo, h_hi} = head[3*COORD_BITS-1:0];
    end else begin
      {v_fix, v_lo, v_hi} = head[3*COORD_BITS-1:0];
      {h_fix, h_lo, h_hi} = probe[3*COORD_BITS-1:0];
    end
  end

  // parallel segments never cross
  assign hit = (p_vert != h_vert) &&
               (h_lo < v_fix) && (v_fix < h_hi) &&
               (v_lo < h_fix) && (h_fix < v_hi);

endmodule

/* sv/orthogonal_segment_pair_finder.sv */
// ----------------------------------------------------------------------------
// orthogonal_segment_pair_finder
// reports strict crossings of each new axis-aligned segment with those stored
// ----------------------------------------------------------------------------
// Each add transaction is tested against every stored segment; one crossing
// transaction (stored index, new index) is sent per hit in index order, then a
// done transaction with the hit count and last set, and the segment is stored
// under the next index. Segments are kept in a ring of MAX_SEGMENTS cells that
// rotates one place per cycle, unless a crossing result is held by a stall,
// past a single comparator at the head, so the done result of an add is
// registered after one full turn of the ring and the done/store state; the
// next transaction can be taken once the block is idle again. A full store
// answers an add with one reject transaction, registered from the reject
// state that follows acceptance; a clear gives no result. The input is
// stalled while an add or a reject is in progress.
// ----------------------------------------------------------------------------
module orthogonal_segment_pair_finder #(
  parameter int MAX_SEGMENTS = osp_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = osp_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  osp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output osp_pkg::out_t out_data
);
  import osp_pkg::*;

  localparam int ENT_W = 3 * COORD_BITS + 1;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SEGMENTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SEGMENTS);

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_REJ  = 2'd3;

  logic [1:0]       state_r,     state_nxt;
  logic [IDX_W-1:0] idx_r,       idx_nxt;      // index of the entry at the head
  logic [IDX_W-1:0] found_r,     found_nxt;    // crossings found so far
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;      // stored segments
  logic [ENT_W-1:0] probe_r,     probe_nxt;    // segment under test
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r,  out_data_nxt;

  logic [ENT_W-1:0] ring [MAX_SEGMENTS];
  logic [ENT_W-1:0] probe_in;
  logic             head_hit;
  logic             hit_q;
  logic             out_load;
  logic             advance;
  logic             store_new;
  logic             in_acc;
  logic [CNT_W-1:0] idx_ext;

  // widened copies for truncation to the 6-bit result fields
  logic [IDX_W+OUT_IDX_W-1:0] idx_wide, found_wide;
  logic [CNT_W+OUT_IDX_W-1:0] cnt_wide;

  // ring of cells, cell i takes its neighbour i+1 when rotating
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.rot  = advance;
    assign ctl.load = store_new && (cnt_r[IDX_W-1:0] == IDX_W'(i));
    osp_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_data (probe_r),
      .from_next (ring[(i + 1) % MAX_SEGMENTS]),
      .ent       (ring[i])
    );
  end

  osp_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .probe (probe_r),
    .head  (ring[0]),
    .hit   (head_hit)
  );

  // vertical: fixed x, span in y; horizontal: fixed y, span in x
  always_comb begin
    if (in_data.vertical) begin
      probe_in = {1'b1, COORD_BITS'(in_data.xa), COORD_BITS'(in_data.ya),
                  COORD_BITS'(in_data.yb)};
    end else begin
      probe_in = {1'b0, COORD_BITS'(in_data.ya), COORD_BITS'(in_data.xa),
                  COORD_BITS'(in_data.xb)};
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;

  // only entries below the fill count take part
  assign idx_ext   = CNT_W'(idx_r);
  assign hit_q     = (idx_ext < cnt_r) && head_hit;
  assign advance   = (state_r == ST_SCAN) && (!hit_q || out_load);
  assign store_new = (state_r == ST_DONE) && out_load;

  assign idx_wide   = {{OUT_IDX_W{1'b0}}, idx_r};
  assign found_wide = {{OUT_IDX_W{1'b0}}, found_r};
  assign cnt_wide   = {{OUT_IDX_W{1'b0}}, cnt_r};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    probe_nxt     = probe_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op == OP_CLEAR) begin
            cnt_nxt = '0;
          end else if (cnt_r == CNT_FULL) begin
            state_nxt = ST_REJ;
          end else begin
            probe_nxt = probe_in;
            idx_nxt   = '0;
            found_nxt = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (hit_q) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.kind          = KIND_CROSS;
            out_data_nxt.earlier_index = idx_wide[OUT_IDX_W-1:0];
            out_data_nxt.new_index     = cnt_wide[OUT_IDX_W-1:0];
            out_data_nxt.match_count   = '0;
            out_data_nxt.last          = 1'b0;
            found_nxt                  = found_r + 1'b1;
          end
          if (idx_r == IDX_LAST) begin
            idx_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.kind          = KIND_DONE;
          out_data_nxt.earlier_index = '0;
          out_data_nxt.new_index     = cnt_wide[OUT_IDX_W-1:0];
          out_data_nxt.match_count   = found_wide[OUT_IDX_W-1:0];
          out_data_nxt.last          = 1'b1;
          cnt_nxt                    = cnt_r + 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.kind          = KIND_FULL;
          out_data_nxt.earlier_index = '0;
          out_data_nxt.new_index     = '0;
          out_data_nxt.match_count   = '0;
          out_data_nxt.last          = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    probe_r    <= probe_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/osp_crossing_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osp_crossing_checker
// watches both channels, predicts the crossing reports and compares them
// ----------------------------------------------------------------------------
// Every accepted add is tested against a local copy of the segment store, and
// the crossing, done or reject transactions it should cause are queued. Each
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module osp_crossing_checker #(
  parameter int MAX_SEGMENTS = osp_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = osp_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  osp_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  osp_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_results
);
  import osp_pkg::*;

  logic                  seg_vertical [MAX_SEGMENTS];
  logic [COORD_BITS-1:0] seg_fixed    [MAX_SEGMENTS];
  logic [COORD_BITS-1:0] seg_lo       [MAX_SEGMENTS];
  logic [COORD_BITS-1:0] seg_hi       [MAX_SEGMENTS];
  int unsigned           stored_count = 0;
  out_t                  expected_results [$];
  int                    mismatches = 0;

  assign fail_count = mismatches;

  // strict containment on both axes
  function automatic bit spans_cross(
    input logic [COORD_BITS-1:0] v_x, v_lo, v_hi,
    input logic [COORD_BITS-1:0] h_y, h_lo, h_hi
  );
    return (h_lo < v_x) && (v_x < h_hi) && (v_lo < h_y) && (h_y < v_hi);
  endfunction

  task automatic predict_crossings(input in_t txn);
    logic [COORD_BITS-1:0] fixed_c;
    logic [COORD_BITS-1:0] lo_c;
    logic [COORD_BITS-1:0] hi_c;
    int unsigned           hits;
    int unsigned           j;
    bit                    hit;
    out_t                  res;
    if (txn.op == OP_CLEAR) begin
      stored_count = 0;
      return;
    end
    if (stored_count >= MAX_SEGMENTS) begin
      res      = '0;
      res.kind = KIND_FULL;
      res.last = 1'b1;
      expected_results.push_back(res);
      return;
    end
    if (txn.vertical) begin
      fixed_c = txn.xa[COORD_BITS-1:0];
      lo_c    = txn.ya[COORD_BITS-1:0];
      hi_c    = txn.yb[COORD_BITS-1:0];
    end else begin
      fixed_c = txn.ya[COORD_BITS-1:0];
      lo_c    = txn.xa[COORD_BITS-1:0];
      hi_c    = txn.xb[COORD_BITS-1:0];
    end
    hits = 0;
    for (j = 0; j < stored_count; j++) begin
      if (seg_vertical[j] != txn.vertical) begin
        hit = txn.vertical ?
              spans_cross(fixed_c, lo_c, hi_c, seg_fixed[j], seg_lo[j], seg_hi[j]) :
              spans_cross(seg_fixed[j], seg_lo[j], seg_hi[j], fixed_c, lo_c, hi_c);
        if (hit) begin
          res               = '0;
          res.kind          = KIND_CROSS;
          res.earlier_index = OUT_IDX_W'(j);
          res.new_index     = OUT_IDX_W'(stored_count);
          expected_results.push_back(res);
          hits++;
        end
      end
    end
    res             = '0;
    res.kind        = KIND_DONE;
    res.new_index   = OUT_IDX_W'(stored_count);
    res.match_count = OUT_IDX_W'(hits);
    res.last        = 1'b1;
    expected_results.push_back(res);
    seg_vertical[stored_count] = txn.vertical;
    seg_fixed[stored_count]    = fixed_c;
    seg_lo[stored_count]       = lo_c;
    seg_hi[stored_count]       = hi_c;
    stored_count++;
  endtask

  task automatic check_field(input string field, input logic [5:0] want,
                             input logic [5:0] got);
    if (got !== want) begin
      $error("result field %s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      stored_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) predict_crossings(in_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction, kind %0d", out_data.kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 6'(want.kind), 6'(out_data.kind));
          check_field("earlier_index", want.earlier_index, out_data.earlier_index);
          check_field("new_index", want.new_index, out_data.new_index);
          check_field("match_count", want.match_count, out_data.match_count);
          check_field("last", 6'(want.last), 6'(out_data.last));
        end
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

/* bench/orthogonal_segment_pair_finder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orthogonal_segment_pair_finder_tb
// regression for the orthogonal segment pair finder
// ----------------------------------------------------------------------------
// A short directed run covers touching ends, reversed and zero-length spans,
// extreme coordinates and clears. Random bursts of segments on a small grid
// then fill the store, overflow it and clear it again, first under heavy
// result back-pressure, then with a slow sender, then at full rate. The
// checker alongside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module orthogonal_segment_pair_finder_tb;
  import osp_pkg::*;

  localparam int PHASE_ITEMS  = 130;
  // worst case is far below this even with every add giving 64 results
  localparam int LIMIT_CYCLES = 2_000_000;
  // long enough for one ring turn and the done state, with some margin
  localparam int DRAIN_CYCLES = MAX_SEGMENTS_DEF + 8;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          fail_count;
  int          pending_results;
  int          cycle_count    = 0;

  orthogonal_segment_pair_finder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  osp_crossing_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("orthogonal_segment_pair_finder regression: fail");
      $finish;
    end
  end

  // add transaction for one segment; unused coordinate left as given
  function automatic in_t segment(input logic vert, input logic [15:0] xa, ya, xb, yb);
    in_t t;
    t.op       = OP_ADD;
    t.vertical = vert;
    t.xa       = xa;
    t.ya       = ya;
    t.xb       = xb;
    t.yb       = yb;
    return t;
  endfunction

  // clear transaction, other fields are don't-care so fill them with noise
  function automatic in_t clear_txn();
    in_t t;
    t = segment(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    t.op = OP_CLEAR;
    return t;
  endfunction

  // mostly well-formed segments on a 32 x 32 grid so that crossings and
  // touching ends are frequent; some reversed, some anywhere in the plane
  function automatic in_t random_segment();
    in_t         t;
    int unsigned mode;
    logic [15:0] base;
    logic [15:0] fixed_c;
    logic [15:0] lo_c;
    logic [15:0] hi_c;
    logic [15:0] swap;
    t    = clear_txn();
    t.op = OP_ADD;
    mode = $urandom_range(0, 9);
    if (mode == 9) return t;
    // near the top of the range now and then, to toggle the high bits
    base    = (mode == 7) ? 16'hFFE0 : 16'h0000;
    fixed_c = base + 16'($urandom_range(0, 31));
    lo_c    = 16'($urandom_range(0, 30));
    hi_c    = base + 16'($urandom_range(lo_c + 1, 31));
    lo_c    = base + lo_c;
    if (mode == 8) begin
      // reversed span
      swap = lo_c;
      lo_c = hi_c;
      hi_c = swap;
    end
    if (t.vertical) begin
      t.xa = fixed_c;
      t.ya = lo_c;
      t.yb = hi_c;
    end else begin
      t.ya = fixed_c;
      t.xa = lo_c;
      t.xb = hi_c;
    end
    return t;
  endfunction

  // present one transaction and hold it until accepted; valid stays high
  // across back-to-back transactions
  task automatic send_txn(input in_t txn);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= txn;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int phase;
    int sent;
    int burst;
    bit first_burst;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 30;
    recv_stall_pct = 88;

    // directed: clear on an empty store, all coordinate bits set
    send_txn('{OP_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    // full-width horizontal at y = 100
    send_txn(segment(1'b0, 16'd0, 16'd100, 16'hFFFF, 16'hFFFF));
    // plain crossing
    send_txn(segment(1'b1, 16'd500, 16'd0, 16'hFFFF, 16'hFFFF));
    // x on either end of the horizontal span: no crossing
    send_txn(segment(1'b1, 16'd0, 16'd0, 16'd0, 16'd200));
    send_txn(segment(1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd200));
    // vertical span ending on the horizontal's y, from above and below
    send_txn(segment(1'b1, 16'd10, 16'd100, 16'd0, 16'd300));
    send_txn(segment(1'b1, 16'd20, 16'd0, 16'd0, 16'd100));
    // horizontal hitting two stored verticals
    send_txn(segment(1'b0, 16'd5, 16'd150, 16'd600, 16'd0));
    // reversed spans never cross
    send_txn(segment(1'b0, 16'd600, 16'd150, 16'd5, 16'd0));
    send_txn(segment(1'b1, 16'd300, 16'hFFFF, 16'd0, 16'd0));
    // zero-length vertical
    send_txn(segment(1'b1, 16'd300, 16'd100, 16'd0, 16'd100));
    // horizontals on the extreme rows, then one spanning nearly the full width
    send_txn(segment(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'd0));
    send_txn(segment(1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0));
    send_txn(segment(1'b0, 16'd1, 16'd50, 16'hFFFE, 16'd0));
    // indices restart after a clear
    send_txn(clear_txn());
    send_txn(segment(1'b1, 16'd500, 16'd0, 16'd0, 16'd1000));
    send_txn(segment(1'b0, 16'd0, 16'd500, 16'd1000, 16'd0));
    // parallel to the last one, crossing only the vertical
    send_txn(segment(1'b0, 16'd0, 16'd400, 16'd1000, 16'd0));

    // random bursts: each starts from an empty store, the first of every
    // phase overfills it so that reject transactions show up
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 30;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 30;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent        = 0;
      first_burst = 1'b1;
      while (sent < PHASE_ITEMS) begin
        send_txn(clear_txn());
        if (first_burst) burst = MAX_SEGMENTS_DEF + 2;
        else if ($urandom_range(0, 3) == 0) burst = $urandom_range(55, 70);
        else burst = $urandom_range(2, 24);
        first_burst = 1'b0;
        repeat (burst) send_txn(random_segment());
        sent += burst + 1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    // drain, then give the block time to show any stray result
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("orthogonal_segment_pair_finder regression: pass");
    end else begin
      $display("orthogonal_segment_pair_finder regression: fail");
    end
    $finish;
  end

endmodule
